FILE: hw/rtl/udf_pkg.sv
`default_nettype none

package udf_pkg;

  // Replacement character for malformed or forbidden code points.
  localparam logic [31:0] RepChar = 32'h0000_FFFD;

  // One unit of work handed from the front end to the back end. It holds
  // the character that the byte closed, if any, and the byte itself when
  // the byte produces a result of its own.
  typedef struct packed {
    logic        has_pend;
    logic [31:0] pend_value;
    logic [3:0]  pend_bytes;
    logic        has_byte;
    logic [7:0]  byte_val;
  } udf_job_t;

  // Start value of a character for a lead byte 0xC0..0xFF, indexed by the low
  // six bits. The payload bits of the lead byte are kept according to its
  // length prefix.
  function automatic logic [7:0] lead_start(input logic [5:0] idx);
    logic [7:0] res;
    res = 8'h00;
    if (!idx[5]) begin
      res = {3'b000, idx[4:0]};
    end else if (!idx[4]) begin
      res = {4'b0000, idx[3:0]};
    end else if (!idx[3]) begin
      res = {5'b00000, idx[2:0]};
    end else if (!idx[2]) begin
      res = {6'b000000, idx[1:0]};
    end else if (!idx[1]) begin
      res = {7'b0000000, idx[0]};
    end
    return res;
  endfunction

  // Replaces code points below 0x80, surrogates and the two noncharacters
  // at the end of the basic plane.
  function automatic logic [31:0] check_cp(input logic [31:0] c);
    logic bad;
    bad = (c < 32'h0000_0080) ||
          ((c & 32'hFFFF_F800) == 32'h0000_D800) ||
          ((c & 32'hFFFF_FFFE) == 32'h0000_FFFE);
    return bad ? RepChar : c;
  endfunction

  // Folds Polish letters to ASCII lowercase and a few separators to space.
  function automatic logic [31:0] fold_cp(input logic [31:0] c);
    logic [31:0] res;
    case (c) inside
      32'h104, 32'h105:                      res = 32'h61;
      32'h118, 32'h119:                      res = 32'h65;
      32'h106, 32'h107:                      res = 32'h63;
      32'h141, 32'h142:                      res = 32'h6C;
      32'h143, 32'h144:                      res = 32'h6E;
      32'h0D3, 32'h0F3:                      res = 32'h6F;
      32'h179, 32'h17A, 32'h17B, 32'h17C:    res = 32'h7A;
      32'h15A, 32'h15B:                      res = 32'h73;
      32'h2D, 32'h09, 32'h2C, 32'h2E, 32'h27: res = 32'h20;
      default:                               res = c;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/udf_front.sv
`default_nettype none

module udf_front (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                accept_i,
  input  wire [7:0]          byte_in_i,
  output logic               push_o,
  output udf_pkg::udf_job_t  job_o
);
  import udf_pkg::*;

  logic        pend_valid_q, pend_valid_d;
  logic [31:0] pend_value_q, pend_value_d;
  logic [3:0]  pend_bytes_q, pend_bytes_d;
  logic        is_cont;
  logic        is_lead;

  assign is_cont = (byte_in_i[7:6] == 2'b10);
  assign is_lead = (byte_in_i[7:6] == 2'b11);

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_value_d = pend_value_q;
    pend_bytes_d = pend_bytes_q;
    push_o       = 1'b0;
    job_o.has_pend   = pend_valid_q;
    job_o.pend_value = pend_value_q;
    job_o.pend_bytes = pend_bytes_q;
    job_o.has_byte   = !is_lead;
    job_o.byte_val   = byte_in_i;
    if (accept_i) begin
      if (pend_valid_q && is_cont) begin
        // Extend the open character; the accumulator wraps at 32 bits.
        pend_value_d = {pend_value_q[25:0], byte_in_i[5:0]};
        if (pend_bytes_q != 4'hF) begin
          pend_bytes_d = pend_bytes_q + 4'd1;
        end
      end else begin
        push_o = pend_valid_q || !is_lead;
        if (is_lead) begin
          pend_valid_d = 1'b1;
          pend_value_d = {24'h0, lead_start(byte_in_i[5:0])};
          pend_bytes_d = 4'd1;
        end else begin
          pend_valid_d = 1'b0;
          pend_value_d = '0;
          pend_bytes_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_value_q <= '0;
      pend_bytes_q <= '0;
    end else begin
      pend_valid_q <= pend_valid_d;
      pend_value_q <= pend_value_d;
      pend_bytes_q <= pend_bytes_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/udf_queue.sv
`default_nettype none

module udf_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     push_i,
  input  wire udf_pkg::udf_job_t  push_job_i,
  input  wire                     pop_i,
  output logic                    full_o,
  output logic                    empty_o,
  output udf_pkg::udf_job_t       head_o
);
  import udf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  udf_job_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/udf_back.sv
`default_nettype none

module udf_back (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     empty_i,
  input  wire udf_pkg::udf_job_t  head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output logic [31:0]             code_point_o,
  output logic [3:0]              byte_count_o,
  output logic                    last_of_run_o
);
  import udf_pkg::*;

  logic        phase_q, phase_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] cp_q, cp_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        last_q, last_d;
  logic        slot_free;
  logic        emit;
  logic        emit_pend;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign emit      = !empty_i && slot_free;
  // The closed character goes out first, then the byte's own result.
  assign emit_pend = head_i.has_pend && !phase_q;

  always_comb begin
    phase_d     = phase_q;
    out_valid_d = out_valid_q && out_stall_i;
    cp_d        = cp_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    pop_o       = 1'b0;
    if (emit) begin
      out_valid_d = 1'b1;
      if (emit_pend) begin
        cp_d   = fold_cp(check_cp(head_i.pend_value));
        cnt_d  = head_i.pend_bytes;
        last_d = !head_i.has_byte;
        if (head_i.has_byte) begin
          phase_d = 1'b1;
        end else begin
          pop_o = 1'b1;
        end
      end else begin
        cp_d    = fold_cp({24'h0, head_i.byte_val});
        cnt_d   = 4'd1;
        last_d  = 1'b1;
        pop_o   = 1'b1;
        phase_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q   <= cp_d;
    cnt_q  <= cnt_d;
    last_q <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign code_point_o  = cp_q;
  assign byte_count_o  = cnt_q;
  assign last_of_run_o = last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/utf8_decode_fold_unit.sv
`default_nettype none
// A result goes from the accepted request through the queue write, then the output register;
// a character closes only on the byte after it.
// Throughput: one byte request per cycle unless the queue is full; a byte that closes a
// character and yields its own result makes two results, which the job queue absorbs.
// Reset (rst_ni, asynchronous, active low) drops the open character and empties the queue.

module utf8_decode_fold_unit #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [31:0] code_point_o,
  output logic [3:0]  byte_count_o,
  output logic        last_of_run_o
);
  import udf_pkg::*;

  // The front end keeps the open character and turns each byte request into
  // at most one job: the closed character, the byte's own result, or both.
  // The back end checks, folds and emits one result per cycle unless idle or stalled.
  logic     accept;
  logic     push;
  logic     pop;
  logic     full;
  logic     empty;
  udf_job_t push_job;
  udf_job_t head_job;

  // The front end stalls only when the queue is full, so a request is taken
  // while a finished result still waits in the output register.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  udf_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .byte_in_i (byte_in_i),
    .push_o    (push),
    .job_o     (push_job)
  );

  udf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .full_o     (full),
    .empty_o    (empty),
    .head_o     (head_job)
  );

  udf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head_job),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_point_o  (code_point_o),
    .byte_count_o  (byte_count_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

`default_nettype wire
